// ===== hdl/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// Used by ffha_cell and first_fit_heap_allocator; depends on nothing.
package ffha_pkg;

	localparam int unsigned DEF_MAX_BLOCKS   = 64;
	localparam int unsigned DEF_HEADER_BYTES = 16;

	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [1:0] FN_MALLOC  = 2'd0;
	localparam logic [1:0] FN_CALLOC  = 2'd1;
	localparam logic [1:0] FN_REALLOC = 2'd2;
	localparam logic [1:0] FN_FREE    = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NULL    = 2'd1;
	localparam logic [1:0] STAT_UNKNOWN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = CFG_IDX_W'(1);

	localparam logic [31:0] RST_HEAP_BASE  = 32'd65536;
	localparam logic [31:0] RST_HEAP_LIMIT = 32'd1048576;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] user_addr;
		logic [31:0] req_size;
		logic [31:0] elem_count;
	} req_t;

	typedef struct packed {
		logic [31:0] result_addr;
		logic [1:0]  status;
		logic [31:0] clear_len;
		logic [31:0] copy_len;
	} rsp_t;

	// One block table entry as held by a cell.
	typedef struct packed {
		logic [31:0] size;
		logic        is_free;
	} entry_t;

	// Per-cell control: shift takes the neighbor's entry, wr loads data.
	typedef struct packed {
		logic   shift;
		logic   wr;
		logic   wr_size;
		entry_t data;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_APPLY,
		S_REL,
		S_DEL,
		S_DONE
	} state_t;

endpackage

// ===== hdl/ffha_cell.sv =====
// One cell of the block table chain: holds a single entry.
// Depends on ffha_pkg for entry_t and cell_ctrl_t.
module ffha_cell import ffha_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     nbr,
	output entry_t     ent
);

	entry_t ent_q;

	// take the neighbor on a shift, else load a direct write
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			ent_q <= nbr;
		end else if (ctrl.wr) begin
			if (ctrl.wr_size) begin
				ent_q.size <= ctrl.data.size;
			end
			ent_q.is_free <= ctrl.data.is_free;
		end
	end

	assign ent = ent_q;

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// First-fit heap allocator top level: controller plus the chain of table cells.
// Depends on ffha_pkg and ffha_cell.
//
// Accepts a malloc, calloc, realloc or free request when start is high and
// busy is low, and returns exactly one result on rsp, marked by done high
// for a single cycle. The receiver cannot stall: sample rsp whenever done is high.
// A request passes from the accepting edge through a prepare step, the scan
// of the whole table, an apply step and the done cycle. A free or a moving
// realloc that releases a block adds a release step, plus a delete step per
// neighbor merged. The next request may be accepted at the end of the cycle
// after done, so a request is never taken before the last one is through.
// The block table lives in a chain of MAX_BLOCKS cells that rotates one full
// turn per request, so the table is read one entry per cycle at the head cell.
// Table writes, appends and merges are applied after the turn by direct
// per-cell writes and by shifting the upper part of the chain down.
// Configuration writes (cfg_valid/cfg_ready) are taken only while idle;
// writing heap_base empties the table.
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int unsigned MAX_BLOCKS   = DEF_MAX_BLOCKS,
	parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	output logic                 done,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
	// header address accumulator: wide enough for a full table of max sizes
	localparam int unsigned HW    = 34 + IDX_W;

	localparam logic [31:0]      HB32 = 32'(HEADER_BYTES);
	localparam logic [33:0]      HB34 = 34'(HEADER_BYTES);
	localparam logic [HW-1:0]    HBW  = HW'(HEADER_BYTES);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_BLOCKS - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_BLOCKS);

	state_t state_q, state_d;

	// control registers
	logic [CNT_W-1:0] nblk_q;
	logic [31:0]      top_q;
	logic [31:0]      base_q;
	logic [31:0]      limit_q;

	// request and scan capture registers
	req_t             req_q;
	logic [63:0]      prod_q;
	logic [IDX_W-1:0] j_q;
	logic [HW-1:0]    hdr_q;
	logic             found_q;
	logic [IDX_W-1:0] fidx_q;
	logic [31:0]      fsize_q;
	logic [31:0]      psize_q;
	logic             pfree_q;
	logic [31:0]      nsize_q;
	logic             nfree_q;
	logic             capn_q;
	logic [31:0]      prev_size_q;
	logic             prev_free_q;
	logic             fit_q;
	logic [IDX_W-1:0] fitidx_q;
	logic [31:0]      fitaddr_q;
	logic [IDX_W-1:0] del_k_q;
	logic             del_n_q;
	rsp_t             rsp_q;

	// chain
	entry_t     ent [MAX_BLOCKS];
	cell_ctrl_t cctl [MAX_BLOCKS];

	// cell operation bus
	logic             op_rot;
	logic             op_del;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic             wr_size_en;
	entry_t           wr_data;

	// scan helpers
	entry_t        head;
	logic          scan_valid;
	logic [HW-1:0] pay_w;
	logic          scan_match;
	logic          scan_fit;

	// decision helpers
	logic [31:0] need;
	logic [33:0] top_sum;
	logic        can_append;
	logic        alloc_ok;
	logic        want, do_alloc, moving, keep, unk, rel_free;
	logic        alloc_done, use_fit, use_app, go_rel;
	logic        rel_last;
	rsp_t        rsp_d;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
			localparam int unsigned NXT = (gi == MAX_BLOCKS - 1) ? 0 : gi + 1;
			always_comb begin
				cctl[gi].shift   = op_rot || (op_del && (IDX_W'(gi) >= del_k_q));
				cctl[gi].wr      = wr_en && (wr_idx == IDX_W'(gi));
				cctl[gi].wr_size = wr_size_en;
				cctl[gi].data    = wr_data;
			end
			ffha_cell u_cell (
				.clk  (clk),
				.ctrl (cctl[gi]),
				.nbr  (ent[NXT]),
				.ent  (ent[gi])
			);
		end
	endgenerate

	// the head cell shows entry j during the turn
	assign head       = ent[0];
	assign scan_valid = CNT_W'(j_q) < nblk_q;
	assign pay_w      = hdr_q + HBW;
	assign scan_match = scan_valid && !found_q && (pay_w == HW'(req_q.user_addr));
	assign scan_fit   = scan_valid && !fit_q && head.is_free && (head.size >= need);

	// allocation request size and growth check at the heap top
	assign need       = (req_q.func == FN_CALLOC) ? prod_q[31:0] : req_q.req_size;
	assign top_sum    = 34'(top_q) + HB34 + 34'(need);
	assign can_append = (nblk_q < FULL) && (top_sum <= 34'(limit_q));
	assign alloc_ok   = fit_q || can_append;

	// decide what the request does once the turn is over
	always_comb begin
		want     = 1'b0;
		do_alloc = 1'b0;
		moving   = 1'b0;
		keep     = 1'b0;
		unk      = 1'b0;
		rel_free = 1'b0;
		unique case (req_q.func)
			FN_MALLOC: begin
				want     = 1'b1;
				do_alloc = req_q.req_size != 32'd0;
			end
			FN_CALLOC: begin
				want     = 1'b1;
				do_alloc = (req_q.elem_count != 32'd0) && (req_q.req_size != 32'd0) &&
				           (prod_q[63:32] == 32'd0);
			end
			FN_REALLOC: begin
				if (req_q.user_addr == 32'd0 || req_q.req_size == 32'd0) begin
					want     = 1'b1;
					do_alloc = req_q.req_size != 32'd0;
				end else if (!found_q) begin
					unk = 1'b1;
				end else if (fsize_q >= req_q.req_size) begin
					keep = 1'b1;
				end else begin
					want     = 1'b1;
					do_alloc = 1'b1;
					moving   = 1'b1;
				end
			end
			FN_FREE: begin
				if (req_q.user_addr != 32'd0) begin
					if (!found_q) begin
						unk = 1'b1;
					end else begin
						rel_free = 1'b1;
					end
				end
			end
		endcase
	end

	assign alloc_done = do_alloc && alloc_ok;
	assign use_fit    = alloc_done && fit_q;
	assign use_app    = alloc_done && !fit_q;
	assign go_rel     = rel_free || (moving && alloc_done);
	assign rel_last   = (CNT_W'(fidx_q) + CNT_W'(1)) == nblk_q;

	always_comb begin
		rsp_d = '0;
		if (unk) begin
			rsp_d.status = STAT_UNKNOWN;
		end else if (want && !alloc_done) begin
			rsp_d.status = STAT_NULL;
		end else begin
			rsp_d.status = STAT_OK;
			if (keep) begin
				rsp_d.result_addr = req_q.user_addr;
			end else if (use_fit) begin
				rsp_d.result_addr = fitaddr_q;
			end else if (use_app) begin
				rsp_d.result_addr = top_q + HB32;
			end
			if (alloc_done && req_q.func == FN_CALLOC) begin
				rsp_d.clear_len = prod_q[31:0];
			end
			if (alloc_done && moving) begin
				rsp_d.copy_len = fsize_q;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) begin
				state_d = S_PREP;
			end
			S_PREP:  state_d = S_SCAN;
			S_SCAN:  if (j_q == LAST) begin
				state_d = S_APPLY;
			end
			S_APPLY: state_d = go_rel ? S_REL : S_DONE;
			S_REL:   state_d = (!rel_last && (pfree_q || nfree_q)) ? S_DEL : S_DONE;
			S_DEL:   if (!del_n_q) begin
				state_d = S_DONE;
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and cell operations
	always_comb begin
		op_rot     = 1'b0;
		op_del     = 1'b0;
		wr_en      = 1'b0;
		wr_idx     = '0;
		wr_size_en = 1'b0;
		wr_data    = '0;
		unique case (state_q)
			S_SCAN: op_rot = 1'b1;
			S_APPLY: begin
				// mark the first fit used, or append a new entry at the end
				if (use_fit) begin
					wr_en  = 1'b1;
					wr_idx = fitidx_q;
				end else if (use_app) begin
					wr_en        = 1'b1;
					wr_idx       = nblk_q[IDX_W-1:0];
					wr_size_en   = 1'b1;
					wr_data.size = need;
				end
			end
			S_REL: begin
				if (!rel_last) begin
					wr_en           = 1'b1;
					wr_data.is_free = 1'b1;
					priority if (pfree_q && nfree_q) begin
						wr_idx       = fidx_q - IDX_W'(1);
						wr_size_en   = 1'b1;
						wr_data.size = psize_q + fsize_q + nsize_q + HB32 + HB32;
					end else if (pfree_q) begin
						wr_idx       = fidx_q - IDX_W'(1);
						wr_size_en   = 1'b1;
						wr_data.size = psize_q + HB32 + fsize_q;
					end else if (nfree_q) begin
						wr_idx       = fidx_q;
						wr_size_en   = 1'b1;
						wr_data.size = fsize_q + HB32 + nsize_q;
					end else begin
						wr_idx = fidx_q;
					end
				end
			end
			S_DEL: op_del = 1'b1;
			default: begin
			end
		endcase
	end

	assign busy      = state_q != S_IDLE;
	assign cfg_ready = state_q == S_IDLE;
	assign done      = state_q == S_DONE;
	assign rsp       = rsp_q;

	// control state: table length, heap top and the two registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nblk_q  <= '0;
			top_q   <= RST_HEAP_BASE;
			base_q  <= RST_HEAP_BASE;
			limit_q <= RST_HEAP_LIMIT;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_HEAP_BASE) begin
					base_q <= cfg_data;
					top_q  <= cfg_data;
					nblk_q <= '0;
				end else if (cfg_index == CFG_HEAP_LIMIT) begin
					limit_q <= cfg_data;
				end
			end
			if (state_q == S_APPLY && use_app) begin
				nblk_q <= nblk_q + CNT_W'(1);
				top_q  <= top_q + HB32 + need;
			end
			if (state_q == S_REL && rel_last) begin
				nblk_q <= nblk_q - CNT_W'(1);
				top_q  <= top_q - HB32 - fsize_q;
			end
			if (state_q == S_DEL) begin
				nblk_q <= nblk_q - CNT_W'(1);
			end
		end
	end

	// request capture, scan bookkeeping and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q <= req;
				end
			end
			S_PREP: begin
				prod_q      <= 64'(req_q.elem_count) * 64'(req_q.req_size);
				hdr_q       <= HW'(base_q);
				j_q         <= '0;
				found_q     <= 1'b0;
				fit_q       <= 1'b0;
				capn_q      <= 1'b0;
				nfree_q     <= 1'b0;
				pfree_q     <= 1'b0;
				prev_free_q <= 1'b0;
			end
			S_SCAN: begin
				if (scan_match) begin
					found_q <= 1'b1;
					fidx_q  <= j_q;
					fsize_q <= head.size;
					psize_q <= prev_size_q;
					pfree_q <= prev_free_q;
				end
				capn_q <= scan_match;
				// hold the entry right after the match for merging
				if (capn_q && scan_valid) begin
					nsize_q <= head.size;
					nfree_q <= head.is_free;
				end
				if (scan_fit) begin
					fit_q     <= 1'b1;
					fitidx_q  <= j_q;
					fitaddr_q <= pay_w[31:0];
				end
				prev_size_q <= head.size;
				prev_free_q <= head.is_free;
				hdr_q       <= hdr_q + HBW + HW'(head.size);
				j_q         <= j_q + IDX_W'(1);
			end
			S_APPLY: begin
				rsp_q <= rsp_d;
				// a fit next to the released block is no longer free
				if (use_fit && fitidx_q == fidx_q - IDX_W'(1)) begin
					pfree_q <= 1'b0;
				end
				if (use_fit && fitidx_q == fidx_q + IDX_W'(1)) begin
					nfree_q <= 1'b0;
				end
			end
			S_REL: begin
				del_k_q <= (nfree_q && !pfree_q) ? fidx_q + IDX_W'(1) : fidx_q;
				del_n_q <= pfree_q && nfree_q;
			end
			S_DEL: begin
				del_n_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule
